@@ src/clb_pkg.sv @@
// ----------------------------------------------------------------------------
// clb_pkg - shared types and constants for the character-LCD bus sequencer
// Request codes, register indexes, delays and the queue entry layout.
// ----------------------------------------------------------------------------
package clb_pkg;

	// Request codes
	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_CMD    = 3'd1;
	localparam logic [2:0] OP_DATA   = 3'd2;
	localparam logic [2:0] OP_CURSOR = 3'd3;
	localparam logic [2:0] OP_FLAGS  = 3'd4;
	localparam logic [2:0] OP_GLYPH  = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_EIGHT_BIT_BUS = 2'd0;
	localparam logic [1:0] CFG_ROW_COUNT     = 2'd1;
	localparam logic [1:0] CFG_COLUMN_COUNT  = 2'd2;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 6;

	// Settle delays in microseconds
	localparam logic [15:0] DLY_NONE     = 16'd0;
	localparam logic [15:0] DLY_POWER_UP = 16'd45000;
	localparam logic [15:0] DLY_WAKE     = 16'd4500;
	localparam logic [15:0] DLY_FSET     = 16'd100;

	// Live configuration seen by the front and back
	typedef struct packed {
		logic       eight_bit_bus;
		logic [2:0] row_count;
	} cfg_t;

	// One classified request waiting for the back end
	typedef struct packed {
		logic       is_init;   // run the wake-up sequence
		logic       rs;        // register select for a single byte
		logic [7:0] byte_val;  // byte to send; display command for init
	} q_entry_t;

endpackage

@@ src/clb_req_if.sv @@
// ----------------------------------------------------------------------------
// clb_req_if - request channel
// Valid/ready channel carrying one LCD request item.
// ----------------------------------------------------------------------------
interface clb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] byte_value;
	logic [5:0] column;
	logic [1:0] row_sel;
	logic [2:0] glyph_slot;
	logic       display_on;
	logic       cursor_on;
	logic       blink_on;

	modport source (
		output valid, op, byte_value, column, row_sel, glyph_slot,
		       display_on, cursor_on, blink_on,
		input  ready
	);
	modport sink (
		input  valid, op, byte_value, column, row_sel, glyph_slot,
		       display_on, cursor_on, blink_on,
		output ready
	);
endinterface

@@ src/clb_strb_if.sv @@
// ----------------------------------------------------------------------------
// clb_strb_if - strobe channel
// Valid/ready channel carrying one bus strobe item.
// ----------------------------------------------------------------------------
interface clb_strb_if;
	logic        valid;
	logic        ready;
	logic        reg_select;
	logic [7:0]  bus_value;
	logic [15:0] delay_before_us;
	logic        last;

	modport source (
		output valid, reg_select, bus_value, delay_before_us, last,
		input  ready
	);
	modport sink (
		input  valid, reg_select, bus_value, delay_before_us, last,
		output ready
	);
endinterface

@@ src/clb_front.sv @@
// ----------------------------------------------------------------------------
// clb_front - request classifier
// Accepts requests, keeps the display flags and builds queue entries.
// ----------------------------------------------------------------------------
module clb_front import clb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	clb_req_if.sink   req,
	input  logic      q_full,
	output logic      push,
	output q_entry_t  push_data
);

	logic [2:0] flags_q;
	logic       accept;
	logic       op_valid;
	logic [1:0] row_eff;
	logic [7:0] row_base;
	logic [7:0] addr;
	logic [2:0] new_flags;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	// Row clamp and DDRAM address
	always_comb begin
		row_eff = ({1'b0, req.row_sel} >= cfg.row_count) ? 2'd0 : req.row_sel;
		unique case (row_eff)
			2'd0:    row_base = 8'h00;
			2'd1:    row_base = 8'h40;
			2'd2:    row_base = 8'h14;
			default: row_base = 8'h54;
		endcase
		addr = {2'b00, req.column} + row_base;
	end

	assign new_flags = {req.display_on, req.cursor_on, req.blink_on};

	// Classify request into a queue entry
	always_comb begin
		op_valid  = 1'b1;
		push_data = '{is_init: 1'b0, rs: 1'b0, byte_val: req.byte_value};
		unique case (req.op)
			OP_INIT: begin
				push_data.is_init  = 1'b1;
				push_data.byte_val = {5'b00001, 1'b1, flags_q[1:0]};
			end
			OP_CMD: begin
			end
			OP_DATA: begin
				push_data.rs = 1'b1;
			end
			OP_CURSOR: begin
				push_data.byte_val = 8'h80 | addr;
			end
			OP_FLAGS: begin
				push_data.byte_val = {5'b00001, new_flags};
			end
			OP_GLYPH: begin
				push_data.byte_val = {2'b01, req.glyph_slot, 3'b000};
			end
			default: begin
				op_valid = 1'b0;  // unused codes are dropped
			end
		endcase
	end

	assign push = accept && op_valid;

	// Display flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= 3'b000;
		end else if (accept) begin
			if (req.op == OP_INIT) begin
				flags_q[2] <= 1'b1;
			end else if (req.op == OP_FLAGS) begin
				flags_q <= new_flags;
			end
		end
	end

endmodule

@@ src/clb_queue.sv @@
// ----------------------------------------------------------------------------
// clb_queue - two-entry request queue
// Decouples the classifier from the strobe generator.
// ----------------------------------------------------------------------------
module clb_queue import clb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);

	q_entry_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ src/clb_back.sv @@
// ----------------------------------------------------------------------------
// clb_back - strobe generator
// Expands the queue head into bus strobes, one per cycle unless the strobe
// channel stalls, into an output register.
// ----------------------------------------------------------------------------
module clb_back import clb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      head_valid,
	input  q_entry_t  head,
	output logic      pop,
	clb_strb_if.source strb
);

	logic [3:0]  step_q;
	logic        valid_q;
	logic        rs_q;
	logic [7:0]  bus_q;
	logic [15:0] dly_q;
	logic        last_q;

	logic        g_rs;
	logic [7:0]  g_bus;
	logic [15:0] g_dly;
	logic        g_last;
	logic [7:0]  hi_nib;
	logic [7:0]  lo_nib;
	logic [7:0]  disp_hi;
	logic [7:0]  disp_lo;
	logic        load;

	assign hi_nib  = {head.byte_val[7:4], 4'h0};
	assign lo_nib  = {head.byte_val[3:0], 4'h0};
	assign disp_hi = hi_nib;
	assign disp_lo = lo_nib;

	// Strobe for the current step of the head entry
	always_comb begin
		g_rs   = 1'b0;
		g_bus  = 8'h00;
		g_dly  = DLY_NONE;
		g_last = 1'b0;
		if (!head.is_init) begin
			g_rs = head.rs;
			if (cfg.eight_bit_bus) begin
				g_bus  = head.byte_val;
				g_last = 1'b1;
			end else if (step_q[0] == 1'b0) begin
				g_bus = hi_nib;
			end else begin
				g_bus  = lo_nib;
				g_last = 1'b1;
			end
		end else if (cfg.eight_bit_bus) begin
			// wake-up on the 8-bit bus
			unique case (step_q)
				4'd0:    begin g_bus = 8'h30; g_dly = DLY_POWER_UP; end
				4'd1:    begin g_bus = 8'h30; g_dly = DLY_WAKE; end
				4'd2:    begin g_bus = 8'h30; g_dly = DLY_WAKE; end
				4'd3:    begin g_bus = 8'h38; g_dly = DLY_WAKE; end
				4'd4:    g_bus = head.byte_val;
				4'd5:    g_bus = 8'h01;
				4'd6:    g_bus = 8'h06;
				default: begin g_bus = 8'h80; g_dly = DLY_WAKE; g_last = 1'b1; end
			endcase
		end else begin
			// 4-bit wake-up: single wake nibbles, then commands as two nibbles
			unique case (step_q)
				4'd0:    begin g_bus = 8'h30; g_dly = DLY_POWER_UP; end
				4'd1:    begin g_bus = 8'h30; g_dly = DLY_WAKE; end
				4'd2:    begin g_bus = 8'h30; g_dly = DLY_WAKE; end
				4'd3:    begin g_bus = 8'h20; g_dly = DLY_WAKE; end
				4'd4:    begin g_bus = 8'h20; g_dly = DLY_FSET; end
				4'd5:    g_bus = 8'h80;
				4'd6:    g_bus = disp_hi;
				4'd7:    g_bus = disp_lo;
				4'd8:    g_bus = 8'h00;
				4'd9:    g_bus = 8'h10;
				4'd10:   g_bus = 8'h00;
				4'd11:   g_bus = 8'h60;
				4'd12:   begin g_bus = 8'h80; g_dly = DLY_WAKE; end
				default: begin g_bus = 8'h00; g_last = 1'b1; end
			endcase
		end
	end

	assign load = head_valid && (!valid_q || strb.ready);
	assign pop  = load && g_last;

	// Step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 4'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= g_last ? 4'd0 : step_q + 4'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (strb.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			rs_q   <= g_rs;
			bus_q  <= g_bus;
			dly_q  <= g_dly;
			last_q <= g_last;
		end
	end

	assign strb.valid           = valid_q;
	assign strb.reg_select      = rs_q;
	assign strb.bus_value       = bus_q;
	assign strb.delay_before_us = dly_q;
	assign strb.last            = last_q;

endmodule

@@ src/char_lcd_bus_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer - character-LCD request to bus strobe sequencer
// Turns LCD requests into register-select / bus-value strobes with delays.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req.valid/ready      op, byte_value, column, row_sel,
//                                     glyph_slot, display_on, cursor_on, blink_on
//  strb     out  strb.valid/ready     reg_select, bus_value, delay_before_us, last
//  cfg      in   cfg_we               cfg_index, cfg_data (no read-back)
//
//  The back end emits one strobe per cycle while strb is ready: a byte is one
//  strobe on the 8-bit bus and two on the 4-bit bus; init is 8 or 14 strobes.
//  A two-entry queue lets requests be taken while strobes drain.
//  Unused op codes are accepted and produce no strobe.
//  Reset clears the display flags, queue, step counter and config defaults.
//  A stalled strobe holds in the output register; the queue absorbs input.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer import clb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	clb_req_if.sink              req,
	clb_strb_if.source           strb
);

	cfg_t     cfg_q;
	logic     push;
	q_entry_t push_data;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	q_entry_t head;

	// Configuration registers; the column count does not affect sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eight_bit_bus <= 1'b0;
			cfg_q.row_count     <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EIGHT_BIT_BUS: cfg_q.eight_bit_bus <= cfg_data[0];
				CFG_ROW_COUNT:     cfg_q.row_count     <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	clb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	clb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	clb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.strb       (strb)
	);

endmodule

@@ tb/sv/tb_char_lcd_bus_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_bus_sequencer - self-checking bench for the LCD bus sequencer
// Drives request items with bursty timing and checks every strobe item
// against an in-bench model of the sequencer, across several bus and row
// configurations, with a stalling strobe receiver.
// ----------------------------------------------------------------------------
module tb_char_lcd_bus_sequencer;
	import clb_pkg::*;

	// Unused request codes, accepted and dropped
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// LCD command bytes used by the wake-up sequence and the other requests
	localparam logic [7:0] LCD_WAKE      = 8'h30;
	localparam logic [7:0] LCD_GO_4BIT   = 8'h20;
	localparam logic [7:0] LCD_FSET_4BIT = 8'h28;
	localparam logic [7:0] LCD_FSET_8BIT = 8'h38;
	localparam logic [7:0] LCD_DISPLAY   = 8'h08;
	localparam logic [7:0] LCD_CLEAR     = 8'h01;
	localparam logic [7:0] LCD_ENTRY     = 8'h06;
	localparam logic [7:0] LCD_DDRAM     = 8'h80;
	localparam logic [7:0] LCD_CGRAM     = 8'h40;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] byte_value;
		logic [5:0] column;
		logic [1:0] row_sel;
		logic [2:0] glyph_slot;
		logic       display_on;
		logic       cursor_on;
		logic       blink_on;
		logic       hold;       // wait for all strobes before sending
	} lcd_req_t;

	typedef struct packed {
		logic        reg_select;
		logic [7:0]  bus_value;
		logic [15:0] delay_before_us;
		logic        last;
	} lcd_strobe_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	clb_req_if  req_ch ();
	clb_strb_if strb_ch ();

	char_lcd_bus_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.strb      (strb_ch)
	);

	// Model state and configuration
	logic       m_bus8  = 1'b0;
	logic [2:0] m_rows  = 3'd4;
	logic [5:0] m_cols  = 6'd20;
	logic [5:0] m_col   = 6'd0;
	logic [1:0] m_row   = 2'd0;
	logic [2:0] m_flags = 3'd0;

	lcd_req_t    pending_reqs[$];
	lcd_strobe_t expected_strobes[$];
	lcd_strobe_t seq_strobes[$];

	int error_count = 0;
	int cycle_count = 0;

	// Clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 50)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Strobe list building
	task automatic put_strobe(input logic rs, input logic [7:0] bus, input logic [15:0] dly);
		lcd_strobe_t s;
		s.reg_select      = rs;
		s.bus_value       = bus;
		s.delay_before_us = dly;
		s.last            = 1'b0;
		seq_strobes.push_back(s);
	endtask

	task automatic put_byte(input logic rs, input logic [7:0] b, input logic [15:0] dly);
		if (m_bus8) begin
			put_strobe(rs, b, dly);
		end else begin
			put_strobe(rs, {b[7:4], 4'h0}, dly);
			put_strobe(rs, {b[3:0], 4'h0}, DLY_NONE);
		end
	endtask

	// Expected strobes of one accepted request, appended in order
	task automatic predict_strobes(input lcd_req_t r);
		lcd_strobe_t s;
		logic [7:0]  base;
		logic [1:0]  row;
		case (r.op)
			OP_INIT: begin
				put_strobe(1'b0, LCD_WAKE, DLY_POWER_UP);
				put_strobe(1'b0, LCD_WAKE, DLY_WAKE);
				put_strobe(1'b0, LCD_WAKE, DLY_WAKE);
				if (m_bus8) begin
					put_byte(1'b0, LCD_FSET_8BIT, DLY_WAKE);
				end else begin
					put_strobe(1'b0, LCD_GO_4BIT, DLY_WAKE);
					put_byte(1'b0, LCD_FSET_4BIT, DLY_FSET);
				end
				m_flags = m_flags | 3'b100;
				put_byte(1'b0, LCD_DISPLAY | {5'd0, m_flags}, DLY_NONE);
				put_byte(1'b0, LCD_CLEAR, DLY_NONE);
				put_byte(1'b0, LCD_ENTRY, DLY_NONE);
				m_col = 6'd0;
				m_row = 2'd0;
				put_byte(1'b0, LCD_DDRAM, DLY_WAKE);
			end
			OP_CMD: begin
				put_byte(1'b0, r.byte_value, DLY_NONE);
			end
			OP_DATA: begin
				put_byte(1'b1, r.byte_value, DLY_NONE);
				m_col = m_col + 6'd1;
			end
			OP_CURSOR: begin
				// out-of-range row falls back to row 0
				row = r.row_sel;
				if ({1'b0, row} >= m_rows)
					row = 2'd0;
				m_col = r.column;
				m_row = row;
				case (row)
					2'd0: base = 8'h00;
					2'd1: base = 8'h40;
					2'd2: base = 8'h14;
					default: base = 8'h54;
				endcase
				// the 8-bit address sum is ORed with the DDRAM bit, which it may already set
				put_byte(1'b0, LCD_DDRAM | ({2'b00, m_col} + base), DLY_NONE);
			end
			OP_FLAGS: begin
				m_flags = {r.display_on, r.cursor_on, r.blink_on};
				put_byte(1'b0, LCD_DISPLAY | {5'd0, m_flags}, DLY_NONE);
			end
			OP_GLYPH: begin
				put_byte(1'b0, LCD_CGRAM | {2'b00, r.glyph_slot, 3'b000}, DLY_NONE);
			end
			default: ;
		endcase
		if (seq_strobes.size() > 0) begin
			s = seq_strobes.pop_back();
			s.last = 1'b1;
			seq_strobes.push_back(s);
		end
		while (seq_strobes.size() > 0)
			expected_strobes.push_back(seq_strobes.pop_front());
	endtask

	// Request driver: bursts of items separated by random gaps
	lcd_req_t cur_req;
	lcd_req_t next_req;
	int       gap_left   = 0;
	int       burst_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				predict_strobes(cur_req);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() > 0)
					next_req = pending_reqs[0];
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0 &&
					     !(next_req.hold && expected_strobes.size() > 0)) begin
					cur_req = pending_reqs.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.op         <= cur_req.op;
					req_ch.byte_value <= cur_req.byte_value;
					req_ch.column     <= cur_req.column;
					req_ch.row_sel    <= cur_req.row_sel;
					req_ch.glyph_slot <= cur_req.glyph_slot;
					req_ch.display_on <= cur_req.display_on;
					req_ch.cursor_on  <= cur_req.cursor_on;
					req_ch.blink_on   <= cur_req.blink_on;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Strobe receiver: stall pattern switches at random among four modes
	int stall_mode  = 0;
	int stall_left  = 0;
	int stall_phase = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end else begin
			stall_left--;
		end
		stall_phase++;
		case (stall_mode)
			0: strb_ch.ready <= 1'b1;
			1: strb_ch.ready <= 1'($urandom_range(0, 1));
			2: strb_ch.ready <= (stall_phase % 4 == 0);
			default: strb_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Strobe checker
	lcd_strobe_t want;

	always @(posedge clk) begin
		if (arst_n && strb_ch.valid && strb_ch.ready) begin
			if (expected_strobes.size() == 0) begin
				report_mismatch($sformatf("unexpected strobe rs=%0d bus=%02h",
					strb_ch.reg_select, strb_ch.bus_value));
			end else begin
				want = expected_strobes.pop_front();
				if (strb_ch.reg_select !== want.reg_select)
					report_mismatch($sformatf("reg_select got %0d want %0d",
						strb_ch.reg_select, want.reg_select));
				if (strb_ch.bus_value !== want.bus_value)
					report_mismatch($sformatf("bus_value got %02h want %02h",
						strb_ch.bus_value, want.bus_value));
				if (strb_ch.delay_before_us !== want.delay_before_us)
					report_mismatch($sformatf("delay_before_us got %0d want %0d",
						strb_ch.delay_before_us, want.delay_before_us));
				if (strb_ch.last !== want.last)
					report_mismatch($sformatf("last got %0d want %0d",
						strb_ch.last, want.last));
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_config(input logic bus8, input logic [2:0] rows, input logic [5:0] cols);
		write_reg(CFG_EIGHT_BIT_BUS, {5'd0, bus8});
		write_reg(CFG_ROW_COUNT, {3'd0, rows});
		write_reg(CFG_COLUMN_COUNT, cols);
		m_bus8 = bus8;
		m_rows = rows;
		m_cols = cols;
	endtask

	// Block until every request is sent and every strobe has arrived
	task automatic wait_idle();
		@(negedge clk);
		while (pending_reqs.size() > 0 || req_ch.valid || expected_strobes.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_req(input logic [2:0] op, input logic [7:0] bv, input logic [5:0] col,
				 input logic [1:0] row, input logic [2:0] slot, input logic [2:0] flags);
		lcd_req_t r;
		r.op         = op;
		r.byte_value = bv;
		r.column     = col;
		r.row_sel    = row;
		r.glyph_slot = slot;
		r.display_on = flags[2];
		r.cursor_on  = flags[1];
		r.blink_on   = flags[0];
		r.hold       = 1'b0;
		pending_reqs.push_back(r);
	endtask

	// Random requests; every field random, op weighted toward common traffic
	task automatic queue_random(input int target, input logic hold_first);
		lcd_req_t    r;
		logic [63:0] rnd;
		int          counted;
		int          w;
		counted = 0;
		while (counted < target) begin
			rnd = {$urandom, $urandom};
			r   = rnd[$bits(lcd_req_t)-1:0];
			w = $urandom_range(0, 99);
			if (w < 4)       r.op = OP_INIT;
			else if (w < 40) r.op = OP_DATA;
			else if (w < 60) r.op = OP_CURSOR;
			else if (w < 72) r.op = OP_CMD;
			else if (w < 84) r.op = OP_FLAGS;
			else if (w < 94) r.op = OP_GLYPH;
			else             r.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
			r.hold = (counted == 0 && hold_first) || ($urandom_range(0, 39) == 0);
			pending_reqs.push_back(r);
			if (r.op != OP_SPARE_A && r.op != OP_SPARE_B)
				counted++;
		end
	endtask

	int ph;

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.op          = OP_INIT;
		req_ch.byte_value  = 8'h00;
		req_ch.column      = 6'd0;
		req_ch.row_sel     = 2'd0;
		req_ch.glyph_slot  = 3'd0;
		req_ch.display_on  = 1'b0;
		req_ch.cursor_on   = 1'b0;
		req_ch.blink_on    = 1'b0;
		strb_ch.ready      = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset configuration, 4-bit bus, four rows
		queue_req(OP_INIT,   8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_CMD,    8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_CMD,    8'hFF, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_DATA,   8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_DATA,   8'hFF, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_CURSOR, 8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_CURSOR, 8'h00, 6'd39, 2'd1, 3'd0, 3'b000);
		// largest column on the last row carries the address into bit 7
		queue_req(OP_CURSOR, 8'h00, 6'd63, 2'd3, 3'd0, 3'b000);
		queue_req(OP_CURSOR, 8'h00, 6'd5,  2'd2, 3'd0, 3'b000);
		queue_req(OP_FLAGS,  8'h00, 6'd0,  2'd0, 3'd0, 3'b111);
		queue_req(OP_FLAGS,  8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_FLAGS,  8'h00, 6'd0,  2'd0, 3'd0, 3'b101);
		queue_req(OP_GLYPH,  8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_GLYPH,  8'h00, 6'd0,  2'd0, 3'd7, 3'b000);
		queue_req(OP_SPARE_A, 8'hFF, 6'd63, 2'd3, 3'd7, 3'b111);
		queue_req(OP_SPARE_B, 8'hFF, 6'd63, 2'd3, 3'd7, 3'b111);
		// init keeps cursor and blink flags, forces display on
		queue_req(OP_INIT,   8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		wait_idle();

		// Directed: 8-bit bus, one row
		set_config(1'b1, 3'd1, 6'd40);
		queue_req(OP_INIT,   8'h00, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_CURSOR, 8'h00, 6'd10, 2'd3, 3'd0, 3'b000);
		queue_req(OP_CMD,    8'hA5, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_DATA,   8'h5A, 6'd0,  2'd0, 3'd0, 3'b000);
		queue_req(OP_FLAGS,  8'h00, 6'd0,  2'd0, 3'd0, 3'b010);
		queue_req(OP_GLYPH,  8'h00, 6'd0,  2'd0, 3'd5, 3'b000);
		wait_idle();

		// Directed: 4-bit bus, two rows
		set_config(1'b0, 3'd2, 6'd1);
		queue_req(OP_CURSOR, 8'h00, 6'd63, 2'd1, 3'd0, 3'b000);
		queue_req(OP_CURSOR, 8'h00, 6'd7,  2'd2, 3'd0, 3'b000);
		wait_idle();

		// Random phases over several configurations
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(1'b0, 3'd4, 6'd40);
				1: set_config(1'b1, 3'd1, 6'd1);
				2: set_config(1'b0, 3'd1, 6'd20);
				3: set_config(1'b1, 3'd4, 6'd40);
				4: set_config(1'b0, 3'd3, 6'd16);
				default: set_config(1'($urandom_range(0, 1)), 3'($urandom_range(1, 4)),
						    6'($urandom_range(1, 40)));
			endcase
			queue_random(50, ph == 2);
			wait_idle();
		end

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
